// File: design/ascii_to_integer_parser_assert.svh
// Assertion macros for the ASCII to integer parser.
`ifndef ASCII_TO_INTEGER_PARSER_ASSERT_SVH
`define ASCII_TO_INTEGER_PARSER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define ATOI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atoi assertion failed");

// Consequent in the cycle after the antecedent.
`define ATOI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atoi assertion failed");

`endif

// File: design/atoi_pkg.sv
// Types and constants shared by the ASCII to integer parser modules.
package atoi_pkg;

  localparam logic [2:0] PH_WS     = 3'd0;
  localparam logic [2:0] PH_PFX0   = 3'd1;
  localparam logic [2:0] PH_PFXX   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [1:0] BM_AUTO = 2'd0;
  localparam logic [1:0] BM_OCT  = 2'd1;
  localparam logic [1:0] BM_DEC  = 2'd2;
  localparam logic [1:0] BM_HEX  = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LC  = 8'h78;
  localparam logic [7:0] CH_X_UC  = 8'h58;

  typedef struct packed {
    logic       ws;
    logic       ok;
    logic [3:0] val;
  } digit_info_t;

endpackage

// File: design/atoi_digit.sv
// Byte classifier: whitespace flag and digit value in a given base.
module atoi_digit
  import atoi_pkg::*;
(
  input  logic [7:0]  c,
  input  logic [1:0]  base,
  output digit_info_t info
);

  always_comb begin
    info.ws  = c inside {[8'd9:8'd13], 8'd32};
    info.ok  = 1'b0;
    info.val = 4'd0;
    if (c inside {["0":"9"]}) begin
      info.val = 4'(c - "0");
      info.ok  = !(base == BM_OCT && c > "7");
    end else if (base == BM_HEX && c inside {["a":"f"]}) begin
      info.val = 4'(c - "a" + 8'd10);
      info.ok  = 1'b1;
    end else if (base == BM_HEX && c inside {["A":"F"]}) begin
      info.val = 4'(c - "A" + 8'd10);
      info.ok  = 1'b1;
    end
  end

endmodule

// File: design/atoi_core.sv
// Parse state, per-byte update and result register.
module atoi_core
  import atoi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  base_mode,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_number,
  output logic        out_ok
);

  logic [2:0]  phase_r, phase_nxt;
  logic        minus_r, minus_nxt;
  logic [1:0]  base_r, base_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        bad_r, bad_nxt;

  logic        res_valid_r, res_valid_nxt;
  logic [63:0] res_acc_r;
  logic        res_minus_r;
  logic        res_ok_r;

  logic        step;
  logic [1:0]  dbase;
  logic        do_digit;
  digit_info_t info;
  logic [67:0] prod;
  logic [67:0] sum;
  logic        ovf;

  assign in_ready = !in_last || !res_valid_r || out_ready;
  assign step     = in_valid && in_ready;
  assign dbase    = (phase_r != PH_WS) ? base_r :
                    (base_mode != BM_AUTO) ? base_mode : BM_DEC;

  atoi_digit u_digit (
    .c    (in_byte),
    .base (dbase),
    .info (info)
  );

  always_comb begin
    case (dbase)
      BM_OCT:  prod = {1'b0, acc_r, 3'b000};
      BM_HEX:  prod = {acc_r, 4'b0000};
      default: prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
    endcase
    sum = prod + {64'd0, info.val};
    ovf = |sum[67:64];
  end

  always_comb begin
    phase_nxt = phase_r;
    minus_nxt = minus_r;
    base_nxt  = base_r;
    acc_nxt   = acc_r;
    bad_nxt   = bad_r;
    do_digit  = 1'b0;
    case (phase_r)
      PH_WS: begin
        if (!info.ws) begin
          base_nxt  = dbase;
          phase_nxt = (base_mode != BM_AUTO) ? PH_DIGITS : PH_PFX0;
          if (in_byte == CH_MINUS) begin
            minus_nxt = 1'b1;
          end else if (in_byte == CH_PLUS) begin
          end else if (base_mode != BM_AUTO) begin
            do_digit = 1'b1;
          end else if (in_byte == CH_ZERO) begin
            base_nxt  = BM_OCT;
            phase_nxt = PH_PFXX;
          end else begin
            phase_nxt = PH_DIGITS;
            do_digit  = 1'b1;
          end
        end
      end
      PH_PFX0: begin
        if (in_byte == CH_ZERO) begin
          base_nxt  = BM_OCT;
          phase_nxt = PH_PFXX;
        end else begin
          phase_nxt = PH_DIGITS;
          do_digit  = 1'b1;
        end
      end
      PH_PFXX: begin
        phase_nxt = PH_DIGITS;
        if (in_byte == CH_X_LC || in_byte == CH_X_UC) begin
          base_nxt = BM_HEX;
        end else begin
          do_digit = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_digit = 1'b1;
      end
      default: begin
      end
    endcase
    if (do_digit) begin
      if (!info.ok) begin
        phase_nxt = PH_DONE;
        if (in_byte != CH_NUL && !in_last) bad_nxt = 1'b1;
      end else if (ovf) begin
        acc_nxt   = '1;
        phase_nxt = PH_DONE;
        if (!in_last) bad_nxt = 1'b1;
      end else begin
        acc_nxt = sum[63:0];
      end
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (step && in_last) begin
      res_valid_nxt = 1'b1;
    end else if (out_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WS;
      minus_r     <= 1'b0;
      base_r      <= BM_DEC;
      acc_r       <= 64'd0;
      bad_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (step) begin
        if (in_last) begin
          phase_r <= PH_WS;
          minus_r <= 1'b0;
          base_r  <= BM_DEC;
          acc_r   <= 64'd0;
          bad_r   <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          minus_r <= minus_nxt;
          base_r  <= base_nxt;
          acc_r   <= acc_nxt;
          bad_r   <= bad_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      res_acc_r   <= acc_nxt;
      res_minus_r <= minus_nxt;
      res_ok_r    <= !bad_nxt;
    end
  end

  assign out_valid  = res_valid_r;
  assign out_number = res_minus_r ? (64'd0 - res_acc_r) : res_acc_r;
  assign out_ok     = res_ok_r;

endmodule

// File: design/ascii_to_integer_parser.sv
// Top level of the ASCII to integer parser.
// Parses a byte stream into 64-bit integers, one string byte per beat, with
// tlast on the final byte of each string. Leading whitespace and one sign are
// skipped, the base comes from cfg_data (auto prefix, octal, decimal or hex),
// and one result beat with the value and an ok flag follows each last byte.
// The block takes one byte per cycle while a pending result does not stall it:
// each byte is registered, then updates the accumulator through a single
// shift-add of the 64-bit value by 8, 10 or 16, and the result beat comes
// from a result register. Write cfg_data only while no string is in flight.
`include "ascii_to_integer_parser_assert.svh"

module ascii_to_integer_parser
  import atoi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,     // base_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] char_byte
  input  logic        in_tlast,     // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata     // [63:0] value, [64] ok, [71:65] zero
);

  logic [1:0]  base_mode_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        core_ready;
  logic [63:0] value;
  logic        ok;

  assign cfg_ready = 1'b1;
  assign in_tready = !s1_valid_r || core_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_mode_r <= BM_AUTO;
      s1_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) base_mode_r <= cfg_data;
      if (in_tready) s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  atoi_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .base_mode  (base_mode_r),
    .in_valid   (s1_valid_r),
    .in_byte    (s1_byte_r),
    .in_last    (s1_last_r),
    .in_ready   (core_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_number (value),
    .out_ok     (ok)
  );

  assign out_tdata = {7'd0, ok, value};

  `ATOI_ASSERT_NEXT(a_stage_hold, s1_valid_r && !in_tready,
                    s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r))
  `ATOI_ASSERT_SAME(a_last_blocks, s1_valid_r && s1_last_r && out_tvalid && !out_tready,
                    !in_tready)
  `ATOI_ASSERT_NEXT(a_no_spurious, s1_valid_r && !s1_last_r && !out_tvalid,
                    !out_tvalid)

endmodule

// File: sim/tb_ascii_to_integer_parser.sv
// Testbench for ascii_to_integer_parser: table and random strings vs a parse predictor.
`timescale 1ns / 100ps

module tb_ascii_to_integer_parser;
  import atoi_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]   mode;
    logic [255:0] text;
    int           len;
    bit           known;
    logic [63:0]  value;
    logic         ok;
  } str_row_t;

  typedef struct {
    logic [63:0] value;
    logic        ok;
  } parse_res_t;

  typedef struct {
    bit         known;
    parse_res_t res;
  } known_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = BM_AUTO;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;    // [7:0] char_byte
  logic        in_tlast = 1'b0;    // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;          // [63:0] value, [64] ok, [71:65] zero

  // predictor state
  logic [1:0]  base_sel;
  logic [2:0]  cv_phase;
  logic        cv_neg;
  logic [1:0]  cv_code;
  logic [63:0] cv_acc;
  logic        cv_bad_end;

  parse_res_t  parsed_q[$];
  known_res_t  known_q[$];
  str_row_t    str_rows[$];
  logic [7:0]  str_q[$];

  logic [1:0]  cfg_now = BM_AUTO;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          miss_cnt = 0;
  int unsigned cycles = 0;
  parse_res_t  exp_r;
  parse_res_t  got_r;
  known_res_t  kn_r;

  ascii_to_integer_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic clear_parse();
    cv_phase   = PH_WS;
    cv_neg     = 1'b0;
    cv_code    = BM_DEC;
    cv_acc     = 64'd0;
    cv_bad_end = 1'b0;
  endtask

  // Advances the parse by one byte.
  task automatic parse_char(input logic [7:0] c, input logic last);
    logic [3:0]  dv;
    logic        dok;
    logic [4:0]  rad;
    logic [67:0] wide;
    if (cv_phase == PH_WS) begin
      if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) return;
      cv_phase = PH_PFX0;
      if (base_sel != BM_AUTO) begin
        cv_code  = base_sel;
        cv_phase = PH_DIGITS;
      end else begin
        cv_code = BM_DEC;
      end
      if (c == CH_MINUS) begin
        cv_neg = 1'b1;
        return;
      end
      if (c == CH_PLUS) return;
    end
    if (cv_phase == PH_PFX0) begin
      if (c == CH_ZERO) begin
        cv_code  = BM_OCT;
        cv_phase = PH_PFXX;
        return;
      end
      cv_phase = PH_DIGITS;
    end else if (cv_phase == PH_PFXX) begin
      cv_phase = PH_DIGITS;
      if (c == CH_X_LC || c == CH_X_UC) begin
        cv_code = BM_HEX;
        return;
      end
    end
    if (cv_phase != PH_DIGITS) return;
    dv  = 4'd0;
    dok = 1'b0;
    if (c >= CH_ZERO && c <= "9") begin
      dv  = 4'(c - CH_ZERO);
      dok = !(cv_code == BM_OCT && c > "7");
    end else if (cv_code == BM_HEX && c >= "a" && c <= "f") begin
      dv  = 4'(c - "a" + 8'd10);
      dok = 1'b1;
    end else if (cv_code == BM_HEX && c >= "A" && c <= "F") begin
      dv  = 4'(c - "A" + 8'd10);
      dok = 1'b1;
    end
    if (!dok) begin
      cv_phase = PH_DONE;
      if (c != CH_NUL && !last) cv_bad_end = 1'b1;
      return;
    end
    case (cv_code)
      BM_OCT:  rad = 5'd8;
      BM_HEX:  rad = 5'd16;
      default: rad = 5'd10;
    endcase
    wide = {4'd0, cv_acc} * {63'd0, rad} + {64'd0, dv};
    if (wide[67:64] != 4'd0) begin
      cv_acc   = '1;
      cv_phase = PH_DONE;
      if (!last) cv_bad_end = 1'b1;
    end else begin
      cv_acc = wide[63:0];
    end
  endtask

  // monitor: result check, config tracking, prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      base_sel = BM_AUTO;
      clear_parse();
    end else begin
      if (out_tvalid && out_tready) begin
        got_r.value = out_tdata[63:0];
        got_r.ok    = out_tdata[64];
        if (parsed_q.size() == 0) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display("unexpected result beat: value %h ok %b", got_r.value, got_r.ok);
        end else begin
          exp_r = parsed_q.pop_front();
          if (got_r.value !== exp_r.value || got_r.ok !== exp_r.ok) begin
            miss_cnt++;
            if (miss_cnt <= 10)
              $display("result mismatch: expected value %h ok %b, got value %h ok %b",
                       exp_r.value, exp_r.ok, got_r.value, got_r.ok);
          end
        end
      end
      if (cfg_valid && cfg_ready) base_sel = cfg_data;
      if (in_tvalid && in_tready) begin
        parse_char(in_tdata, in_tlast);
        if (in_tlast) begin
          exp_r.value = cv_neg ? 64'd0 - cv_acc : cv_acc;
          exp_r.ok    = !cv_bad_end;
          kn_r = known_q.pop_front();
          parsed_q.push_back(kn_r.known ? kn_r.res : exp_r);
          clear_parse();
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
  endtask

  // Base writes only once every pending result has come out.
  task automatic set_base(input logic [1:0] m);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (parsed_q.size() != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_now = m;
  endtask

  task automatic add_row(input logic [1:0] mode, input logic [255:0] text, input int len,
                         input bit known, input logic [63:0] value, input logic ok);
    str_row_t r;
    r.mode  = mode;
    r.text  = text;
    r.len   = len;
    r.known = known;
    r.value = value;
    r.ok    = ok;
    str_rows.push_back(r);
  endtask

  function automatic logic [7:0] rand_digit(input logic [1:0] code);
    int d;
    case (code)
      BM_OCT:  d = $urandom_range(0, 7);
      BM_HEX:  d = $urandom_range(0, 15);
      default: d = $urandom_range(0, 9);
    endcase
    if (d < 10) return 8'(CH_ZERO + d);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
  endfunction

  // Mostly well-formed numbers for the current base, some noise and bad endings.
  task automatic build_string(input logic [1:0] mode);
    int          r;
    int          n;
    logic [1:0]  code;
    logic [7:0]  b;
    str_q.delete();
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 6)) str_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      r = $urandom_range(8, 13);
      str_q.push_back(r == 8 ? 8'd32 : 8'(r));
    end
    r = $urandom_range(0, 3);
    if (r == 0) str_q.push_back(CH_MINUS);
    else if (r == 1) str_q.push_back(CH_PLUS);
    code = mode;
    if (mode == BM_AUTO) begin
      r = $urandom_range(0, 2);
      if (r == 0) begin
        str_q.push_back(CH_ZERO);
        code = BM_OCT;
      end else if (r == 1) begin
        str_q.push_back(CH_ZERO);
        str_q.push_back($urandom_range(0, 1) ? CH_X_LC : CH_X_UC);
        code = BM_HEX;
      end else begin
        code = BM_DEC;
        do b = rand_digit(BM_DEC); while (b == CH_ZERO);
        str_q.push_back(b);
      end
    end
    if ($urandom_range(0, 99) < 15) begin
      case (code)
        BM_OCT:  n = $urandom_range(21, 23);
        BM_HEX:  n = $urandom_range(15, 17);
        default: n = $urandom_range(19, 21);
      endcase
    end else begin
      n = $urandom_range(0, 8);
    end
    repeat (n) str_q.push_back(rand_digit(code));
    if ($urandom_range(0, 99) < 20) begin
      str_q.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) str_q.push_back(8'($urandom_range(0, 255)));
    end
    if (str_q.size() == 0) str_q.push_back(rand_digit(code));
  endtask

  initial begin
    int sent;
    known_res_t k;

    add_row(BM_AUTO, "0", 1, 1, 64'd0, 1'b1);
    add_row(BM_AUTO, " \011\012\013\014\015-42", 9, 1, 64'hFFFF_FFFF_FFFF_FFD6, 1'b1);
    add_row(BM_AUTO, "\0107", 2, 1, 64'd0, 1'b0);
    add_row(BM_AUTO, "\0167", 2, 1, 64'd0, 1'b0);
    add_row(BM_AUTO, "+0x1F", 5, 1, 64'd31, 1'b1);
    add_row(BM_AUTO, "0777", 4, 1, 64'd511, 1'b1);
    add_row(BM_AUTO, "0X7fffffffffffffff", 18, 1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    add_row(BM_AUTO, "18446744073709551615", 20, 1, '1, 1'b1);
    add_row(BM_AUTO, "18446744073709551616", 20, 1, '1, 1'b1);
    add_row(BM_AUTO, "-18446744073709551616", 21, 1, 64'd1, 1'b1);
    add_row(BM_AUTO, "1844674407370955161600", 22, 1, '1, 1'b0);
    add_row(BM_AUTO, "12a3", 4, 1, 64'd12, 1'b0);
    add_row(BM_AUTO, "12\000z", 4, 1, 64'd12, 1'b1);
    add_row(BM_AUTO, "  ", 2, 1, 64'd0, 1'b1);
    add_row(BM_AUTO, "-", 1, 1, 64'd0, 1'b1);
    add_row(BM_AUTO, "0x", 2, 1, 64'd0, 1'b1);
    add_row(BM_AUTO, "098", 3, 1, 64'd0, 1'b0);
    add_row(BM_AUTO, "\377", 1, 1, 64'd0, 1'b1);
    add_row(BM_AUTO, "\2005", 2, 1, 64'd0, 1'b0);
    add_row(BM_AUTO, "-+5", 3, 1, 64'd0, 1'b0);
    add_row(BM_HEX, "0x10", 4, 1, 64'd0, 1'b0);
    add_row(BM_HEX, "FFFFffffFFFFffff", 16, 1, '1, 1'b1);
    add_row(BM_HEX, "-DEADbeef", 9, 0, 64'd0, 1'b0);
    add_row(BM_HEX, "1ffffffffffffffff", 17, 1, '1, 1'b1);
    add_row(BM_OCT, "-17", 3, 0, 64'd0, 1'b0);
    add_row(BM_OCT, "18", 2, 1, 64'd1, 1'b1);
    add_row(BM_OCT, "1777777777777777777777", 22, 1, '1, 1'b1);
    add_row(BM_DEC, "0x5", 3, 1, 64'd0, 1'b0);
    add_row(BM_DEC, " 007", 4, 0, 64'd0, 1'b0);
    add_row(BM_AUTO, "\000", 1, 1, 64'd0, 1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (str_rows[j]) begin
      if (str_rows[j].mode != cfg_now) set_base(str_rows[j].mode);
      k.known     = str_rows[j].known;
      k.res.value = str_rows[j].value;
      k.res.ok    = str_rows[j].ok;
      known_q.push_back(k);
      for (int i = 0; i < str_rows[j].len; i++)
        send_byte(str_rows[j].text[8 * (str_rows[j].len - 1 - i) +: 8],
                  i == str_rows[j].len - 1);
    end

    k.known = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      set_base(2'($urandom_range(0, 3)));
      sent = 0;
      while (sent < 55) begin
        if ($urandom_range(0, 5) == 0) set_base(2'($urandom_range(0, 3)));
        build_string(cfg_now);
        known_q.push_back(k);
        foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
        sent += str_q.size();
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (parsed_q.size() != 0);
    repeat (8) @(posedge clk);
    if (miss_cnt == 0 && parsed_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/atoi_pkg.sv
design/atoi_digit.sv
design/atoi_core.sv
design/ascii_to_integer_parser.sv
sim/tb_ascii_to_integer_parser.sv
